// ----- src/pmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and codes shared by the planar move-toward step core and its cells.
// ----------------------------------------------------------------------------
package pmt_pkg;

    typedef enum logic {
        REG_DEFAULT_SPEED     = 1'b0,
        REG_ARRIVAL_THRESHOLD = 1'b1
    } pmt_reg_t;

    // payload riding along the square root chain
    typedef struct packed {
        logic               ok;
        logic               step_ok;
        logic signed [31:0] dx;
        logic signed [31:0] dz;
        logic        [32:0] step;
    } pmt_sq_pay_t;

    // square root working state
    typedef struct packed {
        logic [63:0] v;
        logic [31:0] root;
        logic [33:0] rem;
    } pmt_sq_st_t;

    // one divider lane
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] rem;
        logic [31:0] quo;
    } pmt_div_lane_t;

    typedef struct packed {
        logic          moved;
        logic          neg_x;
        logic          neg_z;
        logic [31:0]   dvsr;
        pmt_div_lane_t x;
        pmt_div_lane_t z;
    } pmt_div_t;

endpackage

// ----- src/planar_move_toward_step_core.sv -----
// ----------------------------------------------------------------------------
// planar_move_toward_step_core
// Planar move-toward step: distance by root chain, translation by divider chain.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while m_ready stays high and returns one result
// beat per input beat, in order, after three front stages (difference,
// products, sum), a 32-cell square root chain, three check/multiply stages,
// a 32-cell divider chain and the output register.
// ----------------------------------------------------------------------------
module planar_move_toward_step_core import pmt_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_target_valid,
    input  logic               s_positions_valid,
    input  logic signed [30:0] s_self_x,
    input  logic signed [30:0] s_self_z,
    input  logic signed [30:0] s_target_x,
    input  logic signed [30:0] s_target_z,
    input  logic               s_speed_given,
    input  logic signed [31:0] s_speed,
    input  logic signed [31:0] s_delta_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_moved,
    output logic signed [31:0] m_move_x,
    output logic signed [31:0] m_move_z
);

    localparam int NCELL = 32;

    // config registers
    logic [30:0] default_speed_reg;
    logic [15:0] arrival_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_speed_reg     <= 31'(64'd1 << FRAC_BITS);
            arrival_threshold_reg <= 16'd7;
        end else if (cfg_wr_en) begin
            case (pmt_reg_t'(cfg_index))
                REG_DEFAULT_SPEED:     default_speed_reg     <= cfg_wr_data;
                REG_ARRIVAL_THRESHOLD: arrival_threshold_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // stage 0: differences
    logic               v0_reg, en0;
    logic               ok0_reg;
    logic signed [31:0] dx0_reg, dz0_reg, spd0_reg, dt0_reg;
    // stage 1: products
    logic               v1_reg, en1;
    logic               ok1_reg;
    logic signed [31:0] dx1_reg, dz1_reg;
    logic        [63:0] sqx1_reg, sqz1_reg;
    logic signed [63:0] prod1_reg;
    logic        [31:0] adx0, adz0;
    // stage 2: radicand and step
    logic               v2_reg, en2;
    pmt_sq_pay_t        pay2_reg;
    logic        [63:0] sum2_reg;
    logic        [63:0] step_wide;

    logic               sq_valid [NCELL+1];
    logic               sq_ready [NCELL+1];
    pmt_sq_st_t         sq_st    [NCELL+1];
    pmt_sq_pay_t        sq_pay   [NCELL+1];

    assign en0     = !v0_reg || en1;
    assign s_ready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en0) begin
            v0_reg <= s_valid;
        end
        if (en0) begin
            ok0_reg  <= s_target_valid & s_positions_valid;
            dx0_reg  <= 32'(s_target_x) - 32'(s_self_x);
            dz0_reg  <= 32'(s_target_z) - 32'(s_self_z);
            spd0_reg <= s_speed_given ? s_speed : $signed({1'b0, default_speed_reg});
            dt0_reg  <= s_delta_time;
        end
    end

    assign adx0 = dx0_reg[31] ? 32'(-dx0_reg) : 32'(dx0_reg);
    assign adz0 = dz0_reg[31] ? 32'(-dz0_reg) : 32'(dz0_reg);
    assign en1  = !v1_reg || en2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= v0_reg;
        end
        if (en1) begin
            ok1_reg   <= ok0_reg;
            dx1_reg   <= dx0_reg;
            dz1_reg   <= dz0_reg;
            sqx1_reg  <= 64'(adx0) * 64'(adx0);
            sqz1_reg  <= 64'(adz0) * 64'(adz0);
            prod1_reg <= 64'(spd0_reg) * 64'(dt0_reg);
        end
    end

    assign step_wide = 64'(prod1_reg) >> FRAC_BITS;
    assign en2       = !v2_reg || sq_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            sum2_reg         <= sqx1_reg + sqz1_reg;
            pay2_reg.ok      <= ok1_reg;
            pay2_reg.dx      <= dx1_reg;
            pay2_reg.dz      <= dz1_reg;
            pay2_reg.step_ok <= !prod1_reg[63] && (step_wide != 64'd0);
            pay2_reg.step    <= (|step_wide[63:33]) ? '1 : step_wide[32:0];
        end
    end

    // square root chain
    assign sq_valid[0]     = v2_reg;
    assign sq_st[0].v      = sum2_reg;
    assign sq_st[0].root   = '0;
    assign sq_st[0].rem    = '0;
    assign sq_pay[0]       = pay2_reg;

    for (genvar i = 0; i < NCELL; i++) begin : g_sqrt
        pmt_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_st     (sq_st[i]),
            .in_pay    (sq_pay[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_st    (sq_st[i+1]),
            .out_pay   (sq_pay[i+1])
        );
    end

    // stage 3: arrival and step checks
    logic        v3_reg, en3;
    logic        mv3_reg, nx3_reg, nz3_reg;
    logic [31:0] magx3_reg, magz3_reg, step3_reg, dist3_reg;
    logic [31:0] dist_c, adx_c, adz_c, stepc;
    logic        mv_c;
    // stage 4: scaled products
    logic        v4_reg, en4;
    logic        mv4_reg, nx4_reg, nz4_reg;
    logic [63:0] px4_reg, pz4_reg;
    logic [31:0] dist4_reg;
    // stage 5: rounded numerators
    logic        v5_reg, en5;
    logic        mv5_reg, nx5_reg, nz5_reg;
    logic [63:0] nx_num5_reg, nz_num5_reg;
    logic [31:0] dist5_reg;

    logic        dv_valid [NCELL+1];
    logic        dv_ready [NCELL+1];
    pmt_div_t    dv_d     [NCELL+1];

    assign dist_c = sq_st[NCELL].root;
    assign mv_c   = sq_pay[NCELL].ok && sq_pay[NCELL].step_ok
                    && (dist_c > {16'd0, arrival_threshold_reg});
    assign stepc  = (sq_pay[NCELL].step > {1'b0, dist_c}) ? dist_c
                                                          : sq_pay[NCELL].step[31:0];
    assign adx_c  = sq_pay[NCELL].dx[31] ? 32'(-sq_pay[NCELL].dx) : 32'(sq_pay[NCELL].dx);
    assign adz_c  = sq_pay[NCELL].dz[31] ? 32'(-sq_pay[NCELL].dz) : 32'(sq_pay[NCELL].dz);
    assign en3    = !v3_reg || en4;
    assign sq_ready[NCELL] = en3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= sq_valid[NCELL];
        end
        if (en3) begin
            mv3_reg   <= mv_c;
            nx3_reg   <= sq_pay[NCELL].dx[31];
            nz3_reg   <= sq_pay[NCELL].dz[31];
            magx3_reg <= mv_c ? adx_c : '0;
            magz3_reg <= mv_c ? adz_c : '0;
            step3_reg <= mv_c ? stepc : '0;
            dist3_reg <= mv_c ? dist_c : 32'd1;
        end
    end

    assign en4 = !v4_reg || en5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
        if (en4) begin
            mv4_reg   <= mv3_reg;
            nx4_reg   <= nx3_reg;
            nz4_reg   <= nz3_reg;
            dist4_reg <= dist3_reg;
            px4_reg   <= 64'(magx3_reg) * 64'(step3_reg);
            pz4_reg   <= 64'(magz3_reg) * 64'(step3_reg);
        end
    end

    assign en5 = !v5_reg || dv_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
        if (en5) begin
            mv5_reg     <= mv4_reg;
            nx5_reg     <= nx4_reg;
            nz5_reg     <= nz4_reg;
            dist5_reg   <= dist4_reg;
            nx_num5_reg <= px4_reg + 64'(dist4_reg >> 1);
            nz_num5_reg <= pz4_reg + 64'(dist4_reg >> 1);
        end
    end

    // divider chain
    assign dv_valid[0]     = v5_reg;
    assign dv_d[0].moved   = mv5_reg;
    assign dv_d[0].neg_x   = nx5_reg;
    assign dv_d[0].neg_z   = nz5_reg;
    assign dv_d[0].dvsr    = dist5_reg;
    assign dv_d[0].x.rem   = nx_num5_reg[63:32];
    assign dv_d[0].x.lo    = nx_num5_reg[31:0];
    assign dv_d[0].x.quo   = '0;
    assign dv_d[0].z.rem   = nz_num5_reg[63:32];
    assign dv_d[0].z.lo    = nz_num5_reg[31:0];
    assign dv_d[0].z.quo   = '0;

    for (genvar j = 0; j < NCELL; j++) begin : g_div
        pmt_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_d      (dv_d[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_d     (dv_d[j+1])
        );
    end

    // output register
    logic               m_valid_reg, en_o;
    logic               moved_reg;
    logic signed [31:0] move_x_reg, move_z_reg;

    assign en_o            = !m_valid_reg || m_ready;
    assign dv_ready[NCELL] = en_o;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_o) begin
            m_valid_reg <= dv_valid[NCELL];
        end
        if (en_o) begin
            moved_reg  <= dv_d[NCELL].moved;
            move_x_reg <= dv_d[NCELL].neg_x ? $signed(-dv_d[NCELL].x.quo)
                                            : $signed(dv_d[NCELL].x.quo);
            move_z_reg <= dv_d[NCELL].neg_z ? $signed(-dv_d[NCELL].z.quo)
                                            : $signed(dv_d[NCELL].z.quo);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_moved  = moved_reg;
    assign m_move_x = move_x_reg;
    assign m_move_z = move_z_reg;

endmodule

// ----- src/pmt_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// pmt_sqrt_cell
// One root bit of the planar distance: consumes two radicand bits per cell.
// ----------------------------------------------------------------------------
module pmt_sqrt_cell import pmt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pmt_sq_st_t  in_st,
    input  pmt_sq_pay_t in_pay,
    output logic        out_valid,
    input  logic        out_ready,
    output pmt_sq_st_t  out_st,
    output pmt_sq_pay_t out_pay
);

    logic        valid_reg;
    pmt_sq_st_t  st_reg;
    pmt_sq_st_t  st_next;
    pmt_sq_pay_t pay_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        rem_sh    = {in_st.rem, in_st.v[63:62]};
        trial     = {2'b00, in_st.root, 2'b01};
        st_next.v = {in_st.v[61:0], 2'b00};
        if (rem_sh >= trial) begin
            st_next.rem  = 34'(rem_sh - trial);
            st_next.root = {in_st.root[30:0], 1'b1};
        end else begin
            st_next.rem  = rem_sh[33:0];
            st_next.root = {in_st.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            st_reg  <= st_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_pay   = pay_reg;

endmodule

// ----- src/pmt_div_cell.sv -----
// ----------------------------------------------------------------------------
// pmt_div_cell
// One quotient bit for both axes of the scaled translation.
// ----------------------------------------------------------------------------
module pmt_div_cell import pmt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  pmt_div_t in_d,
    output logic     out_valid,
    input  logic     out_ready,
    output pmt_div_t out_d
);

    logic     valid_reg;
    pmt_div_t d_reg;
    pmt_div_t d_next;
    logic     en;

    function automatic pmt_div_lane_t div_step(pmt_div_lane_t l, logic [31:0] dv);
        logic [32:0]   r2;
        pmt_div_lane_t o;
        r2   = {l.rem, l.lo[31]};
        o.lo = {l.lo[30:0], 1'b0};
        if (r2 >= {1'b0, dv}) begin
            o.rem = 32'(r2 - {1'b0, dv});
            o.quo = {l.quo[30:0], 1'b1};
        end else begin
            o.rem = r2[31:0];
            o.quo = {l.quo[30:0], 1'b0};
        end
        return o;
    endfunction

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        d_next   = in_d;
        d_next.x = div_step(in_d.x, in_d.dvsr);
        d_next.z = div_step(in_d.z, in_d.dvsr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

// ----- test/tb_planar_move_toward_step_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planar_move_toward_step_core
// Self-checking bench for the planar move-toward step core: a queue-fed
// driver, a result monitor and an in-bench predictor compare every beat.
// ----------------------------------------------------------------------------
module tb_planar_move_toward_step_core;
    import pmt_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 71;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic               target_valid;
        logic               positions_valid;
        logic signed [30:0] self_x;
        logic signed [30:0] self_z;
        logic signed [30:0] target_x;
        logic signed [30:0] target_z;
        logic               speed_given;
        logic signed [31:0] speed;
        logic signed [31:0] delta_time;
    } move_req_t;

    typedef struct {
        logic               moved;
        logic signed [31:0] move_x;
        logic signed [31:0] move_z;
    } move_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = REG_DEFAULT_SPEED;
    logic [30:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_target_valid = 1'b0;
    logic               s_positions_valid = 1'b0;
    logic signed [30:0] s_self_x = '0;
    logic signed [30:0] s_self_z = '0;
    logic signed [30:0] s_target_x = '0;
    logic signed [30:0] s_target_z = '0;
    logic               s_speed_given = 1'b0;
    logic signed [31:0] s_speed = '0;
    logic signed [31:0] s_delta_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_moved;
    logic signed [31:0] m_move_x;
    logic signed [31:0] m_move_z;

    planar_move_toward_step_core #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [30:0] cur_speed = 31'd65536;
    logic [15:0] cur_threshold = 16'd7;

    move_req_t pending_moves[$];
    move_res_t expected_moves[$];
    int  error_count = 0;
    int  moved_count = 0;
    int  result_count = 0;
    int  stall_cycles = 0;
    bit  stim_done = 1'b0;
    bit  s_taken = 1'b0;
    int  gap_left = 0;
    int  hold_left = 0;

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] scale_toward(longint d, logic [63:0] stp,
                                                       logic [63:0] dist_v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (d < 0) ? -d : d;
        q = (mag * stp + dist_v / 2) / dist_v;
        return (d < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    function automatic move_res_t predict_move(move_req_t r);
        move_res_t   res;
        longint      dx, dz, spd, prod;
        logic [63:0] adx, adz, dist_v, stp;
        res = '{1'b0, 32'sd0, 32'sd0};
        if (!r.target_valid || !r.positions_valid) return res;
        dx = longint'(r.target_x) - longint'(r.self_x);
        dz = longint'(r.target_z) - longint'(r.self_z);
        adx = (dx < 0) ? -dx : dx;
        adz = (dz < 0) ? -dz : dz;
        dist_v = floor_sqrt(adx * adx + adz * adz);
        if (dist_v <= cur_threshold) return res;
        spd = r.speed_given ? longint'(r.speed) : longint'({1'b0, cur_speed});
        prod = spd * longint'(r.delta_time);
        if (prod <= 0) return res;
        stp = prod >> FRAC_BITS;
        if (stp == 0) return res;
        if (stp > dist_v) stp = dist_v;
        res.moved = 1'b1;
        res.move_x = scale_toward(dx, stp, dist_v);
        res.move_z = scale_toward(dz, stp, dist_v);
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [30:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return 31'($signed($urandom_range(0, 31)) - 16);
            1: return $signed(31'($urandom_range(0, 2000000)) - 31'sd1000000);
            2: return $urandom_range(0, 1) ? 31'sh3FFFFFFF : 31'sh40000000;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic move_req_t rand_move();
        move_req_t r;
        r.target_valid    = ($urandom_range(0, 9) != 0);
        r.positions_valid = ($urandom_range(0, 9) != 0);
        r.self_x = rand_pos();
        r.self_z = rand_pos();
        if ($urandom_range(0, 3) == 0) begin
            r.target_x = r.self_x + 31'($signed($urandom_range(0, 40)) - 20);
            r.target_z = r.self_z + 31'($signed($urandom_range(0, 40)) - 20);
        end else begin
            r.target_x = rand_pos();
            r.target_z = rand_pos();
        end
        r.speed_given = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 3))
            0: r.speed = $urandom;
            1: r.speed = $signed($urandom_range(0, 32'h00100000)) - 32'sd4096;
            default: r.speed = $urandom_range(1, 32'h00200000);
        endcase
        case ($urandom_range(0, 3))
            0: r.delta_time = $urandom;
            1: r.delta_time = $signed($urandom_range(0, 8)) - 32'sd4;
            default: r.delta_time = $urandom_range(1, 32'h00010000);
        endcase
        return r;
    endfunction

    task automatic add_move(logic tv, logic pv, int sx, int sz, int tx, int tz,
                            logic sg, int spd, int dt);
        move_req_t r;
        r = '{tv, pv, 31'(sx), 31'(sz), 31'(tx), 31'(tz), sg, spd, dt};
        pending_moves.push_back(r);
    endtask

    task automatic drain_results();
        while (pending_moves.size() != 0 || s_valid || expected_moves.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_reg(pmt_reg_t idx, logic [30:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEFAULT_SPEED) cur_speed = val;
        else cur_threshold = val[15:0];
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (gap_left > 0 || pending_moves.size() == 0) begin
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else begin
                    move_req_t r;
                    r = pending_moves.pop_front();
                    s_valid           <= 1'b1;
                    s_target_valid    <= r.target_valid;
                    s_positions_valid <= r.positions_valid;
                    s_self_x          <= r.self_x;
                    s_self_z          <= r.self_z;
                    s_target_x        <= r.target_x;
                    s_target_z        <= r.target_z;
                    s_speed_given     <= r.speed_given;
                    s_speed           <= r.speed;
                    s_delta_time      <= r.delta_time;
                    gap_left          <= pick_gap();
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else begin
                m_ready   <= ($urandom_range(0, 4) != 0);
                hold_left <= ($urandom_range(0, 30) == 0) ? $urandom_range(10, 50) : 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                move_req_t r;
                r = '{s_target_valid, s_positions_valid, s_self_x, s_self_z,
                      s_target_x, s_target_z, s_speed_given, s_speed, s_delta_time};
                expected_moves.push_back(predict_move(r));
            end
            if (m_valid && m_ready) begin
                move_res_t e;
                result_count++;
                if (expected_moves.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    error_count++;
                end else begin
                    e = expected_moves.pop_front();
                    if (e.moved) moved_count++;
                    if (m_moved !== e.moved || m_move_x !== e.move_x
                        || m_move_z !== e.move_z) begin
                        $display("%0t: expected moved=%0b x=%0d z=%0d got moved=%0b x=%0d z=%0d",
                                 $realtime, e.moved, e.move_x, e.move_z,
                                 m_moved, m_move_x, m_move_z);
                        error_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT && !stim_done) begin
                $display("watchdog: no progress for %0d cycles", stall_cycles);
                $display("tb_planar_move_toward_step_core: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: invalid flags, arrival, non-positive step, clamp, extremes
        add_move(0, 1, 0, 0, 65536000, 0, 1, 65536, 65536);
        add_move(1, 0, 0, 0, 65536000, 0, 1, 65536, 65536);
        add_move(1, 1, 0, 0, 7, 0, 1, 65536, 65536);
        add_move(1, 1, 0, 0, 8, 0, 1, 65536, 6553600);
        add_move(1, 1, 0, 0, 0, 65536000, 1, -65536, 65536);
        add_move(1, 1, 0, 0, 0, 65536000, 1, 65536, -65536);
        add_move(1, 1, 0, 0, 65536000, 0, 1, 1, 1);
        add_move(1, 1, 0, 0, 65536000, 65536000, 1, 65536, 65536);
        add_move(1, 1, 0, 0, 655360, -655360, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_move(1, 1, 0, 0, 655360, 300000, 1, 32'h80000000, 32'h80000000);
        add_move(1, 1, 31'sh40000000, 31'sh40000000, 31'sh3FFFFFFF, 31'sh3FFFFFFF,
                 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_move(1, 1, 31'sh3FFFFFFF, 31'sh40000000, 31'sh40000000, 31'sh3FFFFFFF,
                 1, 65536, 65536);
        add_move(1, 1, 0, 0, -3, 1000, 0, 0, 65536);
        add_move(1, 1, 100, -100, -100, 100, 0, 12345, 3);
        add_move(1, 1, 0, 0, 3, -3, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        drain_results();

        write_reg(REG_DEFAULT_SPEED, 31'h7FFFFFFF);
        write_reg(REG_ARRIVAL_THRESHOLD, 31'h0000FFFF);
        add_move(1, 1, 0, 0, 65535, 0, 0, 0, 65536);
        add_move(1, 1, 0, 0, 65536, 0, 0, 0, 65536);
        add_move(1, 1, 0, 0, -900000, 700000, 0, 0, 2);
        for (int i = 0; i < 350; i++) pending_moves.push_back(rand_move());
        drain_results();

        write_reg(REG_DEFAULT_SPEED, 31'd0);
        write_reg(REG_ARRIVAL_THRESHOLD, 31'd0);
        add_move(1, 1, 0, 0, 1, 0, 1, 65536, 65536);
        add_move(1, 1, 0, 0, 1, 0, 0, 1, 65536);
        for (int i = 0; i < 350; i++) pending_moves.push_back(rand_move());
        drain_results();

        write_reg(REG_DEFAULT_SPEED, 31'($urandom_range(1, 32'h00400000)));
        write_reg(REG_ARRIVAL_THRESHOLD, 31'($urandom_range(1, 200)));
        for (int i = 0; i < 430; i++) pending_moves.push_back(rand_move());
        drain_results();
        stim_done = 1'b1;

        $display("covered %0d result beats, %0d with movement, across four register settings",
                 result_count, moved_count);
        if (error_count == 0) begin
            $display("tb_planar_move_toward_step_core: clean");
        end else begin
            $display("tb_planar_move_toward_step_core: errors");
        end
        $finish;
    end
endmodule
